FILE: rtl/vlo_pkg.sv
// shared types and constants of the voxel log-odds occupancy update
`default_nettype none
package vlo_pkg;

  typedef enum logic [1:0] {
    REQ_OBSERVE = 2'd0,
    REQ_FLUSH   = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  localparam logic [1:0] COL_FREE    = 2'd0;
  localparam logic [1:0] COL_OCC     = 2'd1;
  localparam logic [1:0] COL_UNKNOWN = 2'd2;

  localparam logic signed [15:0] INIT_LOG_ODDS = -16'sd4096;
  localparam logic [15:0]        CNT_MAX       = 16'hFFFF;

  localparam logic [2:0] REG_HIT_INC  = 3'd0;
  localparam logic [2:0] REG_MISS_INC = 3'd1;
  localparam logic [2:0] REG_CLAMP_LO = 3'd2;
  localparam logic [2:0] REG_CLAMP_HI = 3'd3;
  localparam logic [2:0] REG_OCC_THR  = 3'd4;

  typedef struct packed {
    req_e       kind;
    logic       oob;
    logic [5:0] x;
    logic [5:0] y;
    logic [3:0] z;
    logic       hit;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] hit_inc;
    logic signed [15:0] miss_inc;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_hi;
    logic signed [15:0] occ_thr;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/vlo_front.sv
// front end: accepts request items, decodes and range checks them, holds them in a short queue
`default_nettype none
module vlo_front #(
  parameter int SIZE_X = 64,
  parameter int SIZE_Y = 64,
  parameter int SIZE_Z = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [1:0]        req_type_i,
  input  wire  [5:0]        voxel_x_i,
  input  wire  [5:0]        voxel_y_i,
  input  wire  [3:0]        voxel_z_i,
  input  wire               is_hit_i,
  output logic              cmd_valid_o,
  output vlo_pkg::cmd_t     cmd_o,
  input  wire               cmd_pop_i
);

  vlo_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  vlo_pkg::cmd_t dec;
  logic          x_oob, y_oob, z_oob;

  assign x_oob = 32'(voxel_x_i) >= SIZE_X;
  assign y_oob = 32'(voxel_y_i) >= SIZE_Y;
  assign z_oob = 32'(voxel_z_i) >= SIZE_Z;

  always_comb begin
    dec.kind = vlo_pkg::req_e'(req_type_i);
    dec.x    = voxel_x_i;
    dec.y    = voxel_y_i;
    dec.z    = voxel_z_i;
    dec.hit  = is_hit_i;
    unique case (dec.kind)
      vlo_pkg::REQ_OBSERVE: dec.oob = x_oob || y_oob || z_oob;
      vlo_pkg::REQ_QUERY:   dec.oob = x_oob || y_oob;
      default:              dec.oob = 1'b0;
    endcase
  end

  assign in_stall_o  = cnt_q == 2'd2;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vlo_back.sv
// back end: voxel memories, update queue, flush sequencer and result register
`default_nettype none
module vlo_back #(
  parameter int SIZE_X = 64,
  parameter int SIZE_Y = 64,
  parameter int SIZE_Z = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cmd_valid_i,
  input  vlo_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  input  vlo_pkg::cfg_t     cfg_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              status_o,
  output logic [1:0]        column_state_o,
  output logic [16:0]       updated_count_o
);

  localparam int NVOX = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int NCOL = SIZE_X * SIZE_Y;
  localparam int IW   = (NVOX > 1) ? $clog2(NVOX) : 1;
  localparam int CW   = (NCOL > 1) ? $clog2(NCOL) : 1;
  localparam int ZW   = $clog2(SIZE_Z + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_OBS   = 3'd2;
  localparam logic [2:0] ST_QRY   = 3'd3;
  localparam logic [2:0] ST_FQ    = 3'd4;
  localparam logic [2:0] ST_FV    = 3'd5;
  localparam logic [2:0] ST_FS    = 3'd6;

  logic signed [15:0] occ_mem [NVOX];
  logic [31:0]        cnt_mem [NVOX];
  logic [15:0]        que_mem [NVOX];
  logic [1:0]         col_mem [NCOL];

  logic [2:0]  state_q, state_d;
  logic [IW:0] clr_q, clr_d;
  logic [IW:0] pc_q, pc_d;
  logic [IW:0] fi_q, fi_d;
  logic [ZW-1:0] zc_q, zc_d;
  logic        pend_q, pend_d;
  logic [5:0]  cx_q, cx_d, cy_q, cy_d;
  logic [3:0]  cz_q, cz_d;
  logic        ch_q, ch_d;
  logic        ov_q, ov_d;
  logic        st_q, st_d;
  logic [1:0]  cs_q, cs_d;
  logic [16:0] uc_q, uc_d;

  logic signed [15:0] occ_rd_q, occ_wdata;
  logic [31:0] cnt_rd_q, cnt_wdata;
  logic [15:0] que_rd_q;
  logic [1:0]  col_rd_q, col_wdata;
  logic [IW-1:0] occ_raddr, occ_waddr, cnt_raddr, cnt_waddr, que_raddr;
  logic [CW-1:0] col_raddr, col_waddr;
  logic occ_we, cnt_we, que_we, col_we;

  logic [5:0] ax, ay;
  logic [3:0] az;
  logic [IW-1:0] flat_idx, base_idx;
  logic [CW-1:0] col_idx;

  logic [15:0] obs, hits, mn, diff;
  logic signed [15:0] inc;
  logic signed [16:0] nv;
  logic skip;
  logic [15:0] obs_n, hit_n;

  always_comb begin
    flat_idx = IW'((32'(ax) * SIZE_Y + 32'(ay)) * SIZE_Z + 32'(az));
    base_idx = IW'((32'(ax) * SIZE_Y + 32'(ay)) * SIZE_Z);
    col_idx  = CW'(32'(ay) * SIZE_X + 32'(ax));
  end

  always_comb begin
    obs  = cnt_rd_q[15:0];
    hits = cnt_rd_q[31:16];
    mn   = (hits <= obs) ? hits : obs;
    diff = obs - mn;
    inc  = (hits >= diff) ? cfg_i.hit_inc : cfg_i.miss_inc;
    skip = (inc >= 0 && occ_rd_q >= cfg_i.clamp_hi) ||
           (inc <= 0 && occ_rd_q <= cfg_i.clamp_lo);
    nv = 17'(occ_rd_q) + 17'(inc);
    if (nv < 17'(cfg_i.clamp_lo)) nv = 17'(cfg_i.clamp_lo);
    if (nv > 17'(cfg_i.clamp_hi)) nv = 17'(cfg_i.clamp_hi);
    obs_n = (obs < vlo_pkg::CNT_MAX) ? obs + 16'd1 : obs;
    hit_n = (ch_q && hits < vlo_pkg::CNT_MAX) ? hits + 16'd1 : hits;
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    pc_d = pc_q;
    fi_d = fi_q;
    zc_d = zc_q;
    pend_d = 1'b0;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; ch_d = ch_q;
    ov_d = ov_q && out_stall_i;
    st_d = st_q; cs_d = cs_q; uc_d = uc_q;
    cmd_pop_o = 1'b0;
    ax = cx_q; ay = cy_q; az = cz_q;
    occ_raddr = flat_idx; cnt_raddr = flat_idx; col_raddr = col_idx;
    que_raddr = fi_q[IW-1:0];
    occ_we = 1'b0; occ_waddr = flat_idx; occ_wdata = nv[15:0];
    cnt_we = 1'b0; cnt_waddr = flat_idx; cnt_wdata = '0;
    que_we = 1'b0;
    col_we = 1'b0; col_waddr = col_idx; col_wdata = vlo_pkg::COL_OCC;
    unique case (state_q)
      ST_CLEAR: begin
        occ_we = 1'b1; occ_waddr = clr_q[IW-1:0]; occ_wdata = vlo_pkg::INIT_LOG_ODDS;
        cnt_we = 1'b1; cnt_waddr = clr_q[IW-1:0];
        col_we = 32'(clr_q) < NCOL;
        col_waddr = CW'(clr_q); col_wdata = vlo_pkg::COL_UNKNOWN;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == NVOX - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i && !ov_q) begin
          cmd_pop_o = 1'b1;
          cx_d = cmd_i.x; cy_d = cmd_i.y; cz_d = cmd_i.z; ch_d = cmd_i.hit;
          ax = cmd_i.x; ay = cmd_i.y; az = cmd_i.z;
          st_d = 1'b0; cs_d = vlo_pkg::COL_FREE; uc_d = '0;
          unique case (cmd_i.kind)
            vlo_pkg::REQ_OBSERVE: begin
              if (cmd_i.oob) begin
                ov_d = 1'b1; st_d = 1'b1;
              end else state_d = ST_OBS;
            end
            vlo_pkg::REQ_QUERY: begin
              if (cmd_i.oob) begin
                ov_d = 1'b1; st_d = 1'b1; cs_d = vlo_pkg::COL_UNKNOWN;
              end else state_d = ST_QRY;
            end
            vlo_pkg::REQ_FLUSH: begin
              fi_d = '0;
              que_raddr = '0;
              if (pc_q == '0) ov_d = 1'b1;
              else state_d = ST_FQ;
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      ST_OBS: begin
        cnt_we = 1'b1;
        cnt_wdata = {hit_n, obs_n};
        if (obs == 16'd0 && 32'(pc_q) < NVOX) begin
          que_we = 1'b1;
          pc_d = pc_q + 1'b1;
        end
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRY: begin
        cs_d = col_rd_q;
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FQ: begin
        cx_d = que_rd_q[15:10]; cy_d = que_rd_q[9:4]; cz_d = que_rd_q[3:0];
        ax = que_rd_q[15:10]; ay = que_rd_q[9:4]; az = que_rd_q[3:0];
        state_d = ST_FV;
      end
      ST_FV: begin
        cnt_we = 1'b1;
        if (!skip) begin
          occ_we = 1'b1;
          if (nv > 17'(cfg_i.occ_thr)) col_we = 1'b1;
          else begin
            zc_d = '0;
            state_d = ST_FS;
          end
        end
        if (skip || nv > 17'(cfg_i.occ_thr)) begin
          fi_d = fi_q + 1'b1;
          que_raddr = IW'(fi_q + 1'b1);
          if (fi_q + 1'b1 == pc_q) begin
            ov_d = 1'b1; uc_d = 17'(pc_q); pc_d = '0; state_d = ST_IDLE;
          end else state_d = ST_FQ;
        end
      end
      ST_FS: begin
        occ_raddr = IW'(32'(base_idx) + 32'(zc_q));
        if (32'(zc_q) < SIZE_Z) begin
          zc_d = zc_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q && (occ_rd_q >= cfg_i.occ_thr || 32'(zc_q) == SIZE_Z)) begin
          pend_d = 1'b0;
          if (occ_rd_q < cfg_i.occ_thr) begin
            col_we = 1'b1; col_wdata = vlo_pkg::COL_FREE;
          end
          fi_d = fi_q + 1'b1;
          que_raddr = IW'(fi_q + 1'b1);
          if (fi_q + 1'b1 == pc_q) begin
            ov_d = 1'b1; uc_d = 17'(pc_q); pc_d = '0; state_d = ST_IDLE;
          end else state_d = ST_FQ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    occ_rd_q <= occ_mem[occ_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (que_we) que_mem[pc_q[IW-1:0]] <= {cx_q, cy_q, cz_q};
    que_rd_q <= que_mem[que_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    col_rd_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; ch_q <= ch_d;
    st_q <= st_d; cs_q <= cs_d; uc_q <= uc_d;
    fi_q <= fi_d; zc_q <= zc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pc_q    <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = st_q;
  assign column_state_o  = cs_q;
  assign updated_count_o = uc_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd_pop_o) else $error("item taken during clearing pass");
  a_pop_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !ov_q) else $error("item taken while result still pending");
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pc_q) <= NVOX) else $error("pending count beyond voxel count");
  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FS || state_q == ST_FV) && state_d == ST_IDLE |=> pc_q == '0)
    else $error("queue not emptied after flush");

endmodule
`default_nettype wire

FILE: rtl/voxel_log_odds_occupancy_update.sv
// top level of the voxel log-odds occupancy update: register port and front/back wiring
//
// request items enter on in_valid_i/in_stall_o and each gives one result item on
// out_valid_o/out_stall_i; an item moves at an edge with valid high and stall low.
// a two-entry queue decouples request decode from the memory sequencer, and the
// result register holds a finished item while the receiver stalls; the queue keeps
// taking items until it is full.
// after reset a clearing pass writes every voxel and column entry, one per cycle;
// items wait during it and register writes are taken as ever.
// observe reads and writes back the voxel counters and query reads the column memory,
// each through a registered read; out-of-map and unused requests skip it.
// a flush steps through each queued voxel with a queue read (ST_FQ) and a value update
// (ST_FV), plus a z scan of the occupancy memory (ST_FS), one read a cycle, for each
// voxel whose new value leaves the column test to it. the user must write registers at
// byte addresses 0,4,8,12,16 only while idle; the block does not enforce it.
`default_nettype none
module voxel_log_odds_occupancy_update #(
  parameter int SIZE_X = 64,
  parameter int SIZE_Y = 64,
  parameter int SIZE_Z = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  req_type_i,
  input  wire  [5:0]  voxel_x_i,
  input  wire  [5:0]  voxel_y_i,
  input  wire  [3:0]  voxel_z_i,
  input  wire         is_hit_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        status_o,
  output logic [1:0]  column_state_o,
  output logic [16:0] updated_count_o
);

  vlo_pkg::cfg_t cfg_q;
  vlo_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_inc  <= 16'sd2867;
      cfg_q.miss_inc <= 16'sd1434;
      cfg_q.clamp_lo <= 16'sd492;
      cfg_q.clamp_hi <= 16'sd3973;
      cfg_q.occ_thr  <= 16'sd3277;
    end else if (wr_en) begin
      unique case (reg_idx)
        vlo_pkg::REG_HIT_INC:  cfg_q.hit_inc  <= pwdata[15:0];
        vlo_pkg::REG_MISS_INC: cfg_q.miss_inc <= pwdata[15:0];
        vlo_pkg::REG_CLAMP_LO: cfg_q.clamp_lo <= pwdata[15:0];
        vlo_pkg::REG_CLAMP_HI: cfg_q.clamp_hi <= pwdata[15:0];
        vlo_pkg::REG_OCC_THR:  cfg_q.occ_thr  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vlo_pkg::REG_HIT_INC:  prdata = {16'd0, cfg_q.hit_inc};
      vlo_pkg::REG_MISS_INC: prdata = {16'd0, cfg_q.miss_inc};
      vlo_pkg::REG_CLAMP_LO: prdata = {16'd0, cfg_q.clamp_lo};
      vlo_pkg::REG_CLAMP_HI: prdata = {16'd0, cfg_q.clamp_hi};
      vlo_pkg::REG_OCC_THR:  prdata = {16'd0, cfg_q.occ_thr};
      default:               prdata = '0;
    endcase
  end

  vlo_front #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .voxel_x_i   (voxel_x_i),
    .voxel_y_i   (voxel_y_i),
    .voxel_z_i   (voxel_z_i),
    .is_hit_i    (is_hit_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  vlo_back #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .cfg_i           (cfg_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .column_state_o  (column_state_o),
    .updated_count_o (updated_count_o)
  );

endmodule
`default_nettype wire
